[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cpg_pkg.sv]
// constants, codes and types for the circle point generator
// no dependencies

`timescale 1ns / 1ps

package cpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CENTER_BITS    = 12;
    localparam int RADIUS_BITS    = 11;
    localparam int DEC_BITS       = 16;
    localparam int OUT_BITS       = 14;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [DEC_BITS-1:0] D_INIT      = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] D_STEP_DIAG = DEC_BITS'(10);
    localparam logic [DEC_BITS-1:0] D_STEP_AXIS = DEC_BITS'(6);
    localparam int                  MUL4_SHIFT  = 2;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // order of the eight symmetric points within one step
    typedef enum logic [2:0] {
        OCT_XP_YP,
        OCT_XM_YP,
        OCT_XP_YM,
        OCT_XM_YM,
        OCT_YP_XP,
        OCT_YM_XP,
        OCT_YP_XM,
        OCT_YM_XM
    } t_octant;

endpackage

[rtl/core/cpg_front.sv]
// front end: accepts items, keeps the circle state, runs the decision step
// depends on cpg_pkg

`timescale 1ns / 1ps

module cpg_front import cpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_kind,
    input  logic [CENTER_BITS-1:0] i_center_x,
    input  logic [CENTER_BITS-1:0] i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic                   i_q_ready,
    output logic                   o_q_push,
    output logic [JOB_W-1:0]       o_q_data
);

    logic [COORD_BITS-1:0] r_cx, r_cy, r_x, r_y;
    logic [COORD_BITS-1:0] n_cx, n_cy, n_x, n_y;
    logic [DEC_BITS-1:0]   r_d, n_d;
    logic                  n_done;
    logic [COORD_BITS-1:0] rad;
    logic [COORD_BITS-1:0] y_dec;
    logic [DEC_BITS-1:0]   x_ext;
    logic [DEC_BITS-1:0]   y_ext;

    assign o_in_ready = i_q_ready;
    assign o_q_push   = i_in_valid & i_q_ready;
    assign rad        = COORD_BITS'(i_radius);
    assign y_dec      = r_y - COORD_BITS'(1);
    assign x_ext      = DEC_BITS'(signed'(r_x));
    assign y_ext      = DEC_BITS'(signed'(y_dec));

    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_x    = r_x;
        n_y    = r_y;
        n_d    = r_d;
        n_done = 1'b0;
        if (i_kind == KIND_START) begin
            n_cx = COORD_BITS'(i_center_x);
            n_cy = COORD_BITS'(i_center_y);
            n_x  = '0;
            n_y  = rad;
            n_d  = D_INIT - (DEC_BITS'(signed'(rad)) << 1);
        end else if ($signed(r_y) < $signed(r_x)) begin
            n_done = 1'b1;
        end else begin
            if ($signed(r_d) > 0) begin
                n_y = y_dec;
                n_d = r_d + ((x_ext - y_ext) << MUL4_SHIFT) + D_STEP_DIAG;
            end else begin
                n_d = r_d + (x_ext << MUL4_SHIFT) + D_STEP_AXIS;
            end
            n_x = r_x + COORD_BITS'(1);
        end
    end

    assign o_q_data = {n_done, n_cx, n_cy, n_x, n_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_x  <= '0;
            r_y  <= '0;
            r_d  <= '0;
        end else if (o_q_push) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_x  <= n_x;
            r_y  <= n_y;
            r_d  <= n_d;
        end
    end

endmodule

[rtl/core/cpg_queue.sv]
// short job queue between front and back end
// depends on cpg_pkg

`timescale 1ns / 1ps

module cpg_queue import cpg_pkg::*; #(
    parameter int WIDTH = 4 * COORD_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = i_pop & o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/core/cpg_back.sv]
// back end: walks the eight symmetric points of a job, or a single done beat, into the output register
// depends on cpg_pkg

`timescale 1ns / 1ps

module cpg_back import cpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [JOB_W-1:0]           i_q_data,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_point_x,
    output logic signed [OUT_BITS-1:0] o_point_y,
    output logic                       o_last,
    output logic                       o_done_res
);

    logic                  job_done;
    logic [COORD_BITS-1:0] job_cx, job_cy, job_x, job_y;
    logic [OUT_BITS-1:0]   cx, cy, px, py;
    logic [OUT_BITS-1:0]   n_px, n_py;
    logic                  load, step, is_last;
    t_octant               r_idx;
    logic                  r_valid;
    logic [OUT_BITS-1:0]   r_px, r_py;
    logic                  r_last, r_done;

    assign {job_done, job_cx, job_cy, job_x, job_y} = i_q_data;

    assign cx = OUT_BITS'(job_cx);
    assign cy = OUT_BITS'(job_cy);
    assign px = OUT_BITS'(signed'(job_x));
    assign py = OUT_BITS'(signed'(job_y));

    always_comb begin
        case (r_idx)
            OCT_XP_YP: begin n_px = cx + px; n_py = cy + py; end
            OCT_XM_YP: begin n_px = cx - px; n_py = cy + py; end
            OCT_XP_YM: begin n_px = cx + px; n_py = cy - py; end
            OCT_XM_YM: begin n_px = cx - px; n_py = cy - py; end
            OCT_YP_XP: begin n_px = cx + py; n_py = cy + px; end
            OCT_YM_XP: begin n_px = cx - py; n_py = cy + px; end
            OCT_YP_XM: begin n_px = cx + py; n_py = cy - px; end
            OCT_YM_XM: begin n_px = cx - py; n_py = cy - px; end
            default:   begin n_px = '0;      n_py = '0;      end
        endcase
        if (job_done) begin
            n_px = '0;
            n_py = '0;
        end
    end

    assign load    = !r_valid || i_out_ready;
    assign step    = load && i_q_valid;
    assign is_last = job_done || (r_idx == OCT_YM_XM);
    assign o_q_pop = step && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= OCT_XP_YP;
        end else begin
            if (load) begin
                r_valid <= i_q_valid;
            end
            if (step) begin
                r_idx <= is_last ? OCT_XP_YP : t_octant'(r_idx + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_last <= is_last;
            r_done <= job_done;
        end
    end

    assign o_out_valid = r_valid;
    assign o_point_x   = signed'(r_px);
    assign o_point_y   = signed'(r_py);
    assign o_last      = r_last;
    assign o_done_res  = r_done;

endmodule

[rtl/core/circle_point_generator_unit.sv]
// channel  | signals                                   | beat
// ---------+-------------------------------------------+----------------------------
// input    | i_in_valid/o_in_ready, kind, centre, rad  | one start or advance item
// output   | o_out_valid/i_out_ready, point, last, done | one pixel or done marker
//
// an item is taken and queued; the front can run ahead by up to four items
// each item yields eight beats, one a cycle while the output is ready, or one beat for done,
// all through the single output register
// the first beat of an item is registered in the queue and then in the output register
// synchronous active-low reset clears circle state, queue and output valid
// top level of the circle point generator; depends on cpg_pkg, cpg_front,
// cpg_queue and cpg_back

`timescale 1ns / 1ps

module circle_point_generator_unit import cpg_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_kind,
    input  logic [CENTER_BITS-1:0]     i_center_x,
    input  logic [CENTER_BITS-1:0]     i_center_y,
    input  logic [RADIUS_BITS-1:0]     i_radius,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_point_x,
    output logic signed [OUT_BITS-1:0] o_point_y,
    output logic                       o_last,
    output logic                       o_done_res
);

    localparam int JOB_W = 4 * COORD_BITS + 1;

    logic             q_ready, q_push, q_valid, q_pop;
    logic [JOB_W-1:0] q_wdata, q_rdata;

    cpg_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    cpg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_ready (q_ready),
        .i_data  (q_wdata),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    cpg_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_last      (o_last),
        .o_done_res  (o_done_res)
    );

endmodule

[rtl/core/cpg_checker.sv]
// port-level checks for the circle point generator, bound to the top level
// depends on cpg_pkg and assert_macros.svh

`timescale 1ns / 1ps

`include "assert_macros.svh"

module cpg_checker import cpg_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [OUT_BITS-1:0] o_point_x,
    input logic signed [OUT_BITS-1:0] o_point_y,
    input logic                       o_last,
    input logic                       o_done_res
);

    property p_reset_clears;
        !i_rst_n |=> !o_out_valid;
    endproperty

    property p_done_empty;
        o_out_valid && o_done_res |-> o_last && o_point_x == '0 && o_point_y == '0;
    endproperty

    property p_out_hold;
        o_out_valid && !i_out_ready |=> o_out_valid;
    endproperty

    property p_out_stable;
        o_out_valid && !i_out_ready |=> $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_last) && $stable(o_done_res);
    endproperty

    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, p_reset_clears, "output valid after reset")

    `ASSERT_CLK(a_done_is_empty, i_clk, i_rst_n, p_done_empty, "done beat carries a point")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, p_out_hold, "output valid dropped")

    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, p_out_stable, "stalled beat changed")

endmodule

bind circle_point_generator_unit cpg_checker u_cpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_last      (o_last),
    .o_done_res  (o_done_res)
);
